@@ rtl/core/gamepad_input_conditioner_macros.svh @@
// assertion helpers used by gamepad_input_conditioner
`ifndef GAMEPAD_INPUT_CONDITIONER_MACROS_SVH
`define GAMEPAD_INPUT_CONDITIONER_MACROS_SVH

// checked on every rising clock edge outside reset
`define GIC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("gamepad conditioner check failed");

// checked on every rising clock edge, reset included
`define GIC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("gamepad conditioner reset check failed");

`endif

@@ rtl/core/gic_pkg.sv @@
package gic_pkg;

  // field widths
  localparam int PORT_W  = 2;
  localparam int BTN_W   = 16;
  localparam int AXIS_W  = 8;
  localparam int MASK_W  = 4;
  localparam int MAG_W   = 7;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 7;

  // stream widths
  localparam int S_DATA_W = BTN_W + 2 * AXIS_W;
  localparam int S_USER_W = PORT_W + 1;
  localparam int M_DATA_W = 2 * BTN_W + 2 * AXIS_W;
  localparam int M_USER_W = PORT_W + 1;

  // defaults
  localparam int NUM_PORTS_DEF = 4;
  localparam logic [MASK_W-1:0] CONNECTED_MASK_RST = '0;
  localparam logic [MAG_W-1:0]  DEAD_ZONE_RST      = 7'd16;
  localparam logic [MAG_W-1:0]  MAX_DEFLECTION_RST = 7'd60;

  // register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_CONNECTED_MASK = 2'd0,
    CFG_DEAD_ZONE      = 2'd1,
    CFG_MAX_DEFLECTION = 2'd2
  } cfg_idx_t;

  // live configuration handed to the datapath
  typedef struct packed {
    logic [MASK_W-1:0] connected_mask;
    logic [MAG_W-1:0]  dead_zone;
    logic [MAG_W-1:0]  max_deflection;
  } cfg_t;

  // one captured report
  typedef struct packed {
    logic [PORT_W-1:0]        port;
    logic [BTN_W-1:0]         buttons;
    logic signed [AXIS_W-1:0] raw_x;
    logic signed [AXIS_W-1:0] raw_y;
    logic                     read_error;
  } report_t;

endpackage

@@ rtl/core/gic_cfg_regs.sv @@
module gic_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gic_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [gic_pkg::CFG_D_W-1:0]  cfg_data,
  output gic_pkg::cfg_t                cfg
);
  import gic_pkg::*;

  assign cfg_ready = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.connected_mask <= CONNECTED_MASK_RST;
      cfg.dead_zone      <= DEAD_ZONE_RST;
      cfg.max_deflection <= MAX_DEFLECTION_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_CONNECTED_MASK: cfg.connected_mask <= cfg_data[MASK_W-1:0];
        CFG_DEAD_ZONE:      cfg.dead_zone      <= cfg_data[MAG_W-1:0];
        CFG_MAX_DEFLECTION: cfg.max_deflection <= cfg_data[MAG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/gic_axis_cond.sv @@
module gic_axis_cond (
  input  logic signed [gic_pkg::AXIS_W-1:0] raw,
  input  logic [gic_pkg::MAG_W-1:0]         dead_zone,
  input  logic [gic_pkg::MAG_W-1:0]         max_deflection,
  output logic signed [gic_pkg::AXIS_W-1:0] adj
);
  import gic_pkg::*;

  logic [AXIS_W-1:0] raw_u;
  logic [AXIS_W-1:0] mag;
  logic [AXIS_W-1:0] over;
  logic [MAG_W-1:0]  lim;
  logic              outside;

  // magnitude, -128 maps to 128
  assign raw_u = AXIS_W'(raw);
  assign mag   = raw_u[AXIS_W-1] ? (~raw_u + AXIS_W'(1)) : raw_u;

  // dead zone then clamp on the magnitude
  assign outside = mag > {1'b0, dead_zone};
  assign over    = mag - {1'b0, dead_zone};

  always_comb begin
    if (!outside) begin
      lim = '0;
    end else if (over > {1'b0, max_deflection}) begin
      lim = max_deflection;
    end else begin
      lim = over[MAG_W-1:0];
    end
  end

  // restore sign
  assign adj = raw_u[AXIS_W-1] ? -$signed({1'b0, lim}) : $signed({1'b0, lim});

endmodule

@@ rtl/core/gic_btn_track.sv @@
module gic_btn_track #(
  parameter int NUM_PORTS = gic_pkg::NUM_PORTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        update,
  input  logic [gic_pkg::PORT_W-1:0]  port,
  input  logic [gic_pkg::BTN_W-1:0]   buttons,
  input  logic                        good,
  output logic                        in_range,
  output logic [gic_pkg::BTN_W-1:0]   pressed
);
  import gic_pkg::*;

  localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic [BTN_W-1:0] last_buttons [NUM_PORTS];
  logic [31:0]      port_ext;
  logic [IDX_W-1:0] idx;
  logic [BTN_W-1:0] prev;

  assign port_ext = 32'(port);
  assign idx      = port_ext[IDX_W-1:0];
  assign in_range = port_ext < 32'(NUM_PORTS);
  assign prev     = in_range ? last_buttons[idx] : '0;

  // newly pressed: set now, clear before
  assign pressed = buttons & ~prev;

  // store current word, or clear on a bad report
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        last_buttons[i] <= '0;
      end
    end else if (update && in_range) begin
      last_buttons[idx] <= good ? buttons : '0;
    end
  end

endmodule

@@ rtl/core/gamepad_input_conditioner.sv @@
// channel  | beat fields (low bit up)                     | direction
// s_axis   | tdata: buttons, raw_x, raw_y; tuser: port,   | in
//          |   read_error                                 |
// m_axis   | tdata: held, pressed, adj_x, adj_y;          | out
//          |   tuser: out_port, valid_res                 |
// cfg      | cfg_addr: register index, cfg_data: value    | in
//
// one report per cycle sustained while m_axis takes results; each report
// passes through the input register and leaves from the result register.
// the per-port button store is read and updated in the same cycle as the
// result register loads, so reports of one port may follow back to back.
// synchronous reset clears the stored buttons and both valid flags and
// reloads the config defaults. a stall on m_axis holds the result; s_tready
// then stays high only while the input register is empty.
module gamepad_input_conditioner #(
  parameter int NUM_PORTS = gic_pkg::NUM_PORTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // buttons[15:0], raw_x[23:16], raw_y[31:24]
  input  logic [gic_pkg::S_DATA_W-1:0]  s_tdata,
  // port[1:0], read_error[2]
  input  logic [gic_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // held[15:0], pressed[31:16], adj_x[39:32], adj_y[47:40]
  output logic [gic_pkg::M_DATA_W-1:0]  m_tdata,
  // out_port[1:0], valid_res[2]
  output logic [gic_pkg::M_USER_W-1:0]  m_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gic_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [gic_pkg::CFG_D_W-1:0]   cfg_data
);
  import gic_pkg::*;

  `include "gamepad_input_conditioner_macros.svh"

  cfg_t    cfg;
  report_t rpt;
  logic    rpt_valid;
  logic    advance;
  logic    load;

  logic                     in_range;
  logic                     good;
  logic [BTN_W-1:0]         pressed;
  logic signed [AXIS_W-1:0] adj_x;
  logic signed [AXIS_W-1:0] adj_y;

  gic_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: result register frees when empty or taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !rpt_valid || advance;
  assign load     = rpt_valid && advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (s_tready) begin
      rpt_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rpt.buttons    <= s_tdata[BTN_W-1:0];
      rpt.raw_x      <= s_tdata[BTN_W +: AXIS_W];
      rpt.raw_y      <= s_tdata[BTN_W+AXIS_W +: AXIS_W];
      rpt.port       <= s_tuser[PORT_W-1:0];
      rpt.read_error <= s_tuser[PORT_W];
    end
  end

  // report is good when port connected and read clean
  assign good = in_range && cfg.connected_mask[rpt.port] && !rpt.read_error;

  gic_btn_track #(
    .NUM_PORTS (NUM_PORTS)
  ) u_btn (
    .clk      (clk),
    .rst      (rst),
    .update   (load),
    .port     (rpt.port),
    .buttons  (rpt.buttons),
    .good     (good),
    .in_range (in_range),
    .pressed  (pressed)
  );

  gic_axis_cond u_axis_x (
    .raw            (rpt.raw_x),
    .dead_zone      (cfg.dead_zone),
    .max_deflection (cfg.max_deflection),
    .adj            (adj_x)
  );

  gic_axis_cond u_axis_y (
    .raw            (rpt.raw_y),
    .dead_zone      (cfg.dead_zone),
    .max_deflection (cfg.max_deflection),
    .adj            (adj_y)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= rpt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= {good, rpt.port};
      if (good) begin
        m_tdata <= {adj_y, adj_x, pressed, rpt.buttons};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // checks
  `GIC_ASSERT(a_bad_beat_zero, m_tvalid && !m_tuser[PORT_W] |-> m_tdata == '0)
  `GIC_ASSERT(a_pressed_in_held,
              m_tvalid |-> (m_tdata[2*BTN_W-1:BTN_W] & ~m_tdata[BTN_W-1:0]) == '0)
  `GIC_ASSERT(a_input_holds, rpt_valid && !advance |=> rpt_valid && $stable(rpt))
  `GIC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid && !rpt_valid)

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gic_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 300;
  // index past the last register, writes there must change nothing
  localparam logic [CFG_A_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // one conditioned result as it leaves the block
  typedef struct packed {
    logic [PORT_W-1:0]        port;
    logic [BTN_W-1:0]         held;
    logic [BTN_W-1:0]         pressed;
    logic signed [AXIS_W-1:0] adj_x;
    logic signed [AXIS_W-1:0] adj_y;
    logic                     valid;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic [S_USER_W-1:0]  s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic [M_USER_W-1:0]  m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_A_W-1:0]   cfg_addr = '0;
  logic [CFG_D_W-1:0]   cfg_data = '0;

  gamepad_input_conditioner dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: live registers and per-port button store
  logic [MASK_W-1:0] conn_mask_q = CONNECTED_MASK_RST;
  logic [MAG_W-1:0]  dead_zone_q = DEAD_ZONE_RST;
  logic [MAG_W-1:0]  max_defl_q  = MAX_DEFLECTION_RST;
  logic [BTN_W-1:0]  btn_store [NUM_PORTS_DEF];

  report_t pending_reports[$];
  result_t expected_results[$];
  report_t cur_report = '0;
  logic [BTN_W-1:0] last_sent [NUM_PORTS_DEF];

  logic sender_hold   = 1'b0;
  logic sender_steady = 1'b0;
  int   err_count     = 0;
  int   reports_sent  = 0;
  int   results_seen  = 0;
  int   cfg_writes    = 0;
  int   cycles        = 0;

  initial begin
    for (int i = 0; i < NUM_PORTS_DEF; i++) begin
      btn_store[i] = '0;
      last_sent[i] = '0;
    end
  end

  // dead zone then clamp on one stick axis
  function automatic logic signed [AXIS_W-1:0] shape_axis(logic signed [AXIS_W-1:0] v);
    int sv, dz, mx, r;
    sv = v;
    dz = dead_zone_q;
    mx = max_defl_q;
    if (sv >= -dz && sv <= dz) r = 0;
    else if (sv > dz) r = sv - dz;
    else r = sv + dz;
    if (r > mx) r = mx;
    if (r < -mx) r = -mx;
    return r[AXIS_W-1:0];
  endfunction

  // expected result of one report, updates the button store
  function automatic result_t predict_result(report_t r);
    result_t e;
    e = '0;
    e.port = r.port;
    if (conn_mask_q[r.port] && !r.read_error) begin
      e.held    = r.buttons;
      e.pressed = r.buttons & ~btn_store[r.port];
      e.adj_x   = shape_axis(r.raw_x);
      e.adj_y   = shape_axis(r.raw_y);
      e.valid   = 1'b1;
      btn_store[r.port] = r.buttons;
    end else begin
      btn_store[r.port] = '0;
    end
    return e;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_count < 25)
      $display("ERROR at %0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_reports
    logic    nv;
    report_t nr;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nv = s_tvalid;
      nr = cur_report;
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_result(cur_report));
        reports_sent++;
        nv = 1'b0;
      end
      if (!nv && !sender_hold && pending_reports.size() > 0) begin
        if (gap_left > 0 && !sender_steady) begin
          gap_left--;
        end else begin
          nr = pending_reports.pop_front();
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_tvalid   <= nv;
      cur_report <= nr;
      s_tdata    <= {nr.raw_y, nr.raw_x, nr.buttons};
      s_tuser    <= {nr.read_error, nr.port};
    end
  end

  // receiver: stall pattern switches among a few modes
  int rx_mode   = 0;
  int mode_left = 100;
  int stall_left = 0;

  always @(posedge clk) begin : drive_ready
    logic rdy;
    if (mode_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    case (rx_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 9) < 7);
      2: rdy = ((cycles & 3) != 3);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(2, 12);
        end
      end
    endcase
    m_tready <= rdy;
  end

  // result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", m_tuser, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser[1:0] != want.port)
          report_mismatch("out_port", m_tuser[1:0], want.port);
        if (m_tuser[2] != want.valid)
          report_mismatch("valid_res", m_tuser[2], want.valid);
        if (m_tdata[15:0] != want.held)
          report_mismatch("held", m_tdata[15:0], want.held);
        if (m_tdata[31:16] != want.pressed)
          report_mismatch("pressed", m_tdata[31:16], want.pressed);
        if (m_tdata[39:32] != want.adj_x)
          report_mismatch("adj_x", m_tdata[39:32], want.adj_x);
        if (m_tdata[47:40] != want.adj_y)
          report_mismatch("adj_y", m_tdata[47:40], want.adj_y);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_report(input logic [PORT_W-1:0] p, input logic [BTN_W-1:0] b,
                             input int x, input int y, input bit e);
    report_t r;
    r.port       = p;
    r.buttons    = b;
    r.raw_x      = x[AXIS_W-1:0];
    r.raw_y      = y[AXIS_W-1:0];
    r.read_error = e;
    last_sent[p] = b;
    pending_reports.push_back(r);
  endtask

  // wait until nothing is queued, in flight or outstanding, sampled mid-cycle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reports.size() != 0 || s_tvalid || expected_results.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_CONNECTED_MASK: conn_mask_q = val[MASK_W-1:0];
      CFG_DEAD_ZONE:      dead_zone_q = val;
      CFG_MAX_DEFLECTION: max_defl_q  = val;
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // stick value biased toward the dead zone and clamp edges
  function automatic int rand_axis();
    int pick, v, dz, mx;
    dz = dead_zone_q;
    mx = max_defl_q;
    pick = $urandom_range(0, 19);
    if (pick < 10) v = int'($urandom_range(0, 255)) - 128;
    else if (pick < 14) v = ($urandom_range(0, 1) ? dz : -dz) + int'($urandom_range(0, 4)) - 2;
    else if (pick < 17) v = ($urandom_range(0, 1) ? dz + mx : -dz - mx)
                            + int'($urandom_range(0, 4)) - 2;
    else begin
      case ($urandom_range(0, 2))
        0: v = -128;
        1: v = 127;
        default: v = -127;
      endcase
    end
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v;
  endfunction

  // mostly reports for connected ports with buttons evolving from the last word
  task automatic push_random_report();
    logic [PORT_W-1:0] p;
    logic [BTN_W-1:0]  b;
    int pick;
    p = PORT_W'($urandom_range(0, NUM_PORTS_DEF - 1));
    if (conn_mask_q != '0 && $urandom_range(0, 99) < 85) begin
      while (!conn_mask_q[p]) p = PORT_W'($urandom_range(0, NUM_PORTS_DEF - 1));
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      b = last_sent[p] ^ (16'h1 << $urandom_range(0, 15));
      if ($urandom_range(0, 1)) b = b ^ (16'h1 << $urandom_range(0, 15));
    end else if (pick == 6) begin
      b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      b = BTN_W'($urandom);
    end
    push_report(p, b, rand_axis(), rand_axis(), $urandom_range(0, 11) == 0);
  endtask

  task automatic run_phase(input logic [MASK_W-1:0] mask, input logic [MAG_W-1:0] dz,
                           input logic [MAG_W-1:0] mx, input bit steady, input bit pause);
    wait_idle();
    cfg_write(CFG_MAX_DEFLECTION, mx);
    cfg_write(CFG_CONNECTED_MASK, {3'b000, mask});
    cfg_write(CFG_DEAD_ZONE, dz);
    @(posedge clk);
    sender_steady <= steady;
    for (int i = 0; i < PHASE_ITEMS; i++) push_random_report();
    if (pause) begin
      // hold the sender until the block has drained completely
      while (pending_reports.size() > PHASE_ITEMS / 2) @(posedge clk);
      sender_hold <= 1'b1;
      do @(posedge clk);
      while (s_tvalid || expected_results.size() != 0);
      sender_hold <= 1'b0;
    end
    wait_idle();
  endtask

  // stimulus
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing connected after reset, every result is blank
    push_report(0, 16'hFFFF, 127, -128, 0);
    push_report(3, 16'h1234, 50, 50, 0);
    wait_idle();

    // reset dead zone and clamp with all ports connected
    cfg_write(CFG_CONNECTED_MASK, 7'h0F);
    push_report(0, 16'hFFFF, 127, -128, 0);
    push_report(0, 16'hFFFF, 16, -16, 0);
    push_report(0, 16'h0000, 17, -17, 0);
    push_report(0, 16'hA5A5, 0, 0, 0);
    push_report(0, 16'hA5A5, 40, 40, 1);
    push_report(0, 16'hA5A5, 75, -77, 0);
    push_report(1, 16'h5A5A, 76, -76, 0);
    push_report(1, 16'h5A5B, -1, 1, 0);
    push_report(2, 16'h8001, -127, 127, 0);
    push_report(3, 16'hFFFF, 100, 100, 1);
    push_report(3, 16'h0001, 20, -20, 0);
    wait_idle();

    // a report for a disconnected port clears its stored buttons
    cfg_write(CFG_CONNECTED_MASK, 7'h05);
    push_report(1, 16'hFFFF, 30, 30, 0);
    push_report(2, 16'h8001, 30, 30, 0);
    wait_idle();

    // no dead zone, widest clamp: the most negative raw value
    cfg_write(CFG_CONNECTED_MASK, 7'h0F);
    cfg_write(CFG_DEAD_ZONE, 7'd0);
    cfg_write(CFG_MAX_DEFLECTION, 7'd127);
    push_report(1, 16'hFFFF, -128, 127, 0);
    push_report(2, 16'h7FFE, 1, -1, 0);
    wait_idle();

    // widest dead zone with zero clamp, then with widest clamp
    cfg_write(CFG_DEAD_ZONE, 7'd127);
    cfg_write(CFG_MAX_DEFLECTION, 7'd0);
    push_report(0, 16'h0F0F, -128, 127, 0);
    push_report(3, 16'hF0F0, 100, -100, 0);
    wait_idle();
    cfg_write(CFG_MAX_DEFLECTION, 7'd127);
    push_report(0, 16'hFFFF, -128, 127, 0);
    wait_idle();

    // a write past the last register is ignored
    cfg_write(CFG_UNUSED_IDX, 7'h7F);
    push_report(2, 16'h0000, -128, 126, 0);
    wait_idle();

    // random phases over several register settings
    run_phase(4'hF, 7'd16, 7'd60, 1'b1, 1'b0);
    run_phase(4'hF, 7'd0, 7'd127, 1'b0, 1'b1);
    run_phase(4'hA, 7'd127, 7'd0, 1'b0, 1'b0);
    run_phase(4'h0 | 4'($urandom), 7'($urandom), 7'($urandom), 1'b0, 1'b0);
    run_phase(4'hF, 7'd127, 7'd127, 1'b0, 1'b0);
    run_phase(4'($urandom), 7'($urandom_range(0, 40)), 7'($urandom), 1'b1, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results still outstanding", expected_results.size(), 0);

    $display("checked %0d results from %0d reports, %0d register writes",
             results_seen, reports_sent, cfg_writes);
    $display("covered port masks, dead zone and clamp extremes, read errors, stalls");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/gic_pkg.sv
rtl/core/gic_cfg_regs.sv
rtl/core/gic_axis_cond.sv
rtl/core/gic_btn_track.sv
rtl/core/gamepad_input_conditioner.sv
test/tb.sv
